// File: rtl/rwsp_pkg.sv
// package for the riff wave stream parser
// phase and result codes, chunk names, result queue sizing and queue entry type
// no dependencies
`timescale 1ns / 1ps

package rwsp_pkg;

	typedef enum logic [2:0] {
		PH_HDR  = 3'd0,
		PH_CHDR = 3'd1,
		PH_FMT  = 3'd2,
		PH_DATA = 3'd3,
		PH_SKIP = 3'd4,
		PH_DEAD = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PCM    = 2'd0,
		KIND_FORMAT = 2'd1,
		KIND_ERROR  = 2'd2,
		KIND_DONE   = 2'd3
	} kind_t;

	localparam logic [2:0] ERR_SHORT    = 3'd0;
	localparam logic [2:0] ERR_RIFF     = 3'd1;
	localparam logic [2:0] ERR_WAVE     = 3'd2;
	localparam logic [2:0] ERR_TAG      = 3'd3;
	localparam logic [2:0] ERR_UNSUPP   = 3'd4;

	localparam logic [31:0] NAME_RIFF  = 32'h52494646;
	localparam logic [31:0] NAME_WAVE  = 32'h57415645;
	localparam logic [31:0] NAME_FMT_S = 32'h666D7420;
	localparam logic [31:0] NAME_FMT_Z = 32'h666D7400;
	localparam logic [31:0] NAME_DATA  = 32'h64617461;

	localparam logic [31:0] HDR_LAST_POS = 32'd11;
	localparam logic [31:0] RIFF_END_POS = 32'd3;
	localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
	localparam logic [15:0] FMT_TAG_PCM  = 16'd1;
	localparam logic [15:0] BITS_8       = 16'd8;
	localparam logic [15:0] BITS_16      = 16'd16;

	localparam int RQ_DEPTH = 4;
	localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	localparam int TDATA_W = 80;

	// one queue entry holds all results caused by one item
	typedef struct packed {
		logic        has_primary;
		kind_t       kind;
		logic [7:0]  pcm;
		logic        last;
		logic [1:0]  fmt;
		logic [15:0] chan;
		logic [31:0] rate;
		logic [15:0] bits;
		logic [2:0]  err;
		logic        has_tail;
		kind_t       tail_kind;
	} res_entry_t;

endpackage

// File: rtl/riff_wave_stream_parser.sv
// riff wave stream parser top level
// byte stream in, pcm bytes, format reports and status out
// depends on rwsp_pkg
//
//  channel | dir | tdata                   | tuser       | tlast
//  s_*     | in  | data_byte               | -           | end_of_file
//  m_*     | out | pcm, fmt, ch, rate, ... | result_kind | last_of_chunk
//
// one byte accepted per cycle; it is decoded in the cycle after acceptance
// an item gives zero, one or two results, sent one per cycle from a 4-entry queue
// input stalls while queued entries plus the byte in decode reach 4
// output stalls fill the queue
// results pass through the decode input register and the result queue before they leave
// arst_n clears the parser to the file header phase and empties the queue
`timescale 1ns / 1ps

module riff_wave_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [rwsp_pkg::TDATA_W-1:0] m_tdata,
	                               // [7:0] pcm_byte, [9:8] format_code,
	                               // [25:10] channel_count, [57:26] sample_rate,
	                               // [73:58] bits_per_sample, [76:74] error_code
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	output logic        m_tlast
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;

	rwsp_pkg::phase_t phase_q, phase_n;
	logic [31:0] rem_q, rem_n;
	logic [31:0] len_q, len_n;
	logic [31:0] name_q, name_n;
	logic [15:0] chan_q, chan_n;
	logic [31:0] rate_q, rate_n;
	logic [15:0] bits_q, bits_n;
	logic [15:0] tag_q, tag_n;
	logic        fault_q, fault_n;

	rwsp_pkg::res_entry_t fifo_q [rwsp_pkg::RQ_DEPTH];
	logic [rwsp_pkg::RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [rwsp_pkg::RQ_CNT_W-1:0] count_q;
	logic out_second_q;

	rwsp_pkg::res_entry_t ent;
	logic        has_err;
	logic [2:0]  err_code;
	logic [2:0]  pos;
	logic [31:0] off;
	logic [31:0] rem_dec;
	logic        push, pop, accept;
	rwsp_pkg::res_entry_t head;
	logic        show_primary;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (count_q + rwsp_pkg::RQ_CNT_W'(valid_s1))
		< rwsp_pkg::RQ_CNT_W'(rwsp_pkg::RQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		rem_n    = rem_q;
		len_n    = len_q;
		name_n   = name_q;
		chan_n   = chan_q;
		rate_n   = rate_q;
		bits_n   = bits_q;
		tag_n    = tag_q;
		fault_n  = fault_q;
		has_err  = 1'b0;
		err_code = rwsp_pkg::ERR_SHORT;
		pos      = rem_q[2:0];
		off      = len_q - rem_q;
		rem_dec  = rem_q - 32'd1;
		ent             = '0;
		ent.kind        = rwsp_pkg::KIND_PCM;
		ent.tail_kind   = rwsp_pkg::KIND_DONE;

		unique case (phase_q)
			rwsp_pkg::PH_HDR: begin
				name_n = {name_q[23:0], data_s1};
				if (rem_q == rwsp_pkg::RIFF_END_POS) begin
					fault_n = (name_n != rwsp_pkg::NAME_RIFF);
				end
				if (rem_q >= rwsp_pkg::HDR_LAST_POS) begin
					if (fault_q) begin
						has_err  = 1'b1;
						err_code = rwsp_pkg::ERR_RIFF;
					end else if (name_n != rwsp_pkg::NAME_WAVE) begin
						has_err  = 1'b1;
						err_code = rwsp_pkg::ERR_WAVE;
					end else begin
						phase_n = rwsp_pkg::PH_CHDR;
						rem_n   = '0;
						len_n   = '0;
						name_n  = '0;
					end
				end else begin
					rem_n = rem_q + 32'd1;
				end
			end
			rwsp_pkg::PH_CHDR: begin
				if (!pos[2]) begin
					name_n = {name_q[23:0], data_s1};
				end else begin
					len_n[8*pos[1:0] +: 8] = len_q[8*pos[1:0] +: 8] | data_s1;
				end
				if (pos == 3'd7) begin
					if (name_n == rwsp_pkg::NAME_FMT_S || name_n == rwsp_pkg::NAME_FMT_Z) begin
						if (len_n < rwsp_pkg::FMT_MIN_LEN) begin
							has_err  = 1'b1;
							err_code = rwsp_pkg::ERR_SHORT;
						end else begin
							phase_n = rwsp_pkg::PH_FMT;
							rem_n   = len_n;
							tag_n   = '0;
							chan_n  = '0;
							rate_n  = '0;
							bits_n  = '0;
						end
					end else if (len_n == '0) begin
						phase_n = rwsp_pkg::PH_CHDR;
						rem_n   = '0;
						len_n   = '0;
						name_n  = '0;
					end else begin
						phase_n = (name_n == rwsp_pkg::NAME_DATA) ? rwsp_pkg::PH_DATA
							: rwsp_pkg::PH_SKIP;
						rem_n   = len_n;
					end
				end else begin
					rem_n = {29'd0, pos} + 32'd1;
				end
			end
			rwsp_pkg::PH_FMT: begin
				if (off[31:4] == '0) begin
					unique case (off[3:0])
						4'd0:    tag_n[7:0]   = tag_q[7:0] | data_s1;
						4'd1:    tag_n[15:8]  = tag_q[15:8] | data_s1;
						4'd2:    chan_n[7:0]  = chan_q[7:0] | data_s1;
						4'd3:    chan_n[15:8] = chan_q[15:8] | data_s1;
						4'd4:    rate_n[7:0]  = rate_q[7:0] | data_s1;
						4'd5:    rate_n[15:8] = rate_q[15:8] | data_s1;
						4'd6:    rate_n[23:16] = rate_q[23:16] | data_s1;
						4'd7:    rate_n[31:24] = rate_q[31:24] | data_s1;
						4'd14:   bits_n[7:0]  = bits_q[7:0] | data_s1;
						4'd15:   bits_n[15:8] = bits_q[15:8] | data_s1;
						default: ;
					endcase
				end
				if (off == 32'd1 && tag_n != rwsp_pkg::FMT_TAG_PCM) begin
					has_err  = 1'b1;
					err_code = rwsp_pkg::ERR_TAG;
				end else if (off == 32'd15) begin
					if (chan_n == '0 || (bits_n != rwsp_pkg::BITS_8
						&& bits_n != rwsp_pkg::BITS_16)) begin
						has_err  = 1'b1;
						err_code = rwsp_pkg::ERR_UNSUPP;
					end else begin
						ent.has_primary = 1'b1;
						ent.kind        = rwsp_pkg::KIND_FORMAT;
						ent.fmt         = {chan_n > 16'd1, bits_n == rwsp_pkg::BITS_16};
						ent.chan        = chan_n;
						ent.rate        = rate_n;
						ent.bits        = bits_n;
					end
				end
				if (!has_err) begin
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						phase_n = rwsp_pkg::PH_CHDR;
						len_n   = '0;
						name_n  = '0;
					end
				end
			end
			rwsp_pkg::PH_DATA: begin
				ent.has_primary = 1'b1;
				ent.kind        = rwsp_pkg::KIND_PCM;
				ent.pcm         = data_s1;
				ent.last        = (rem_dec == '0);
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					phase_n = rwsp_pkg::PH_CHDR;
					len_n   = '0;
					name_n  = '0;
				end
			end
			rwsp_pkg::PH_SKIP: begin
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					phase_n = rwsp_pkg::PH_CHDR;
					len_n   = '0;
					name_n  = '0;
				end
			end
			default: ;
		endcase

		if (has_err) begin
			phase_n         = rwsp_pkg::PH_DEAD;
			ent             = '0;
			ent.has_primary = 1'b1;
			ent.kind        = rwsp_pkg::KIND_ERROR;
			ent.err         = err_code;
			ent.tail_kind   = rwsp_pkg::KIND_DONE;
		end else if (last_s1 && phase_n != rwsp_pkg::PH_DEAD) begin
			ent.has_tail  = 1'b1;
			ent.tail_kind = (phase_n == rwsp_pkg::PH_CHDR && rem_n == '0)
				? rwsp_pkg::KIND_DONE : rwsp_pkg::KIND_ERROR;
		end

		if (last_s1) begin
			phase_n = rwsp_pkg::PH_HDR;
			rem_n   = '0;
			len_n   = '0;
			name_n  = '0;
			chan_n  = '0;
			rate_n  = '0;
			bits_n  = '0;
			tag_n   = '0;
			fault_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rwsp_pkg::PH_HDR;
			rem_q   <= '0;
			len_q   <= '0;
			name_q  <= '0;
			chan_q  <= '0;
			rate_q  <= '0;
			bits_q  <= '0;
			tag_q   <= '0;
			fault_q <= 1'b0;
		end else if (valid_s1) begin
			phase_q <= phase_n;
			rem_q   <= rem_n;
			len_q   <= len_n;
			name_q  <= name_n;
			chan_q  <= chan_n;
			rate_q  <= rate_n;
			bits_q  <= bits_n;
			tag_q   <= tag_n;
			fault_q <= fault_n;
		end
	end

	// result queue, one entry per item that gives any result
	assign push = valid_s1 && (ent.has_primary || ent.has_tail);
	assign head = fifo_q[rd_ptr_q];
	assign show_primary = head.has_primary && !out_second_q;
	assign pop = m_tvalid && m_tready && (!show_primary || !head.has_tail);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			rd_ptr_q     <= '0;
			count_q      <= '0;
			out_second_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + rwsp_pkg::RQ_CNT_W'(push) - rwsp_pkg::RQ_CNT_W'(pop);
			if (m_tvalid && m_tready) begin
				out_second_q <= !pop;
			end
		end
	end

	always_comb begin
		m_tvalid = (count_q != '0);
		m_tdata  = '0;
		m_tuser  = head.tail_kind;
		m_tlast  = 1'b0;
		if (show_primary) begin
			m_tuser        = head.kind;
			m_tlast        = head.last;
			m_tdata[7:0]   = head.pcm;
			m_tdata[9:8]   = head.fmt;
			m_tdata[25:10] = head.chan;
			m_tdata[57:26] = head.rate;
			m_tdata[73:58] = head.bits;
			m_tdata[76:74] = head.err;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rwsp_pkg::RQ_CNT_W'(rwsp_pkg::RQ_DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < rwsp_pkg::RQ_CNT_W'(rwsp_pkg::RQ_DEPTH) || pop))
		else $error("push into full result queue");

	a_eof_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1) |=> (phase_q == rwsp_pkg::PH_HDR && rem_q == '0))
		else $error("parser not back at file header after end flag");

	a_dead_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == rwsp_pkg::PH_DEAD && !(valid_s1 && last_s1))
		|=> phase_q == rwsp_pkg::PH_DEAD)
		else $error("parser left error phase without end flag");

	a_second_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_second_q |-> (m_tvalid && head.has_tail))
		else $error("second result shown without a pending tail");
`endif

endmodule
